@@ rtl/tlct_pkg.sv @@
// ----------------------------------------------------------------------------
// tlct_pkg
// Types and constants shared by the command throttle controller and datapath.
// ----------------------------------------------------------------------------
package tlct_pkg;

  localparam logic [2:0] KIND_SUBMIT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_REPLY  = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_FREEZE = 3'd4;
  localparam logic [2:0] KIND_HOLD   = 3'd5;
  localparam logic [2:0] KIND_ATTACH = 3'd6;
  localparam logic [2:0] KIND_DETACH = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_WRONG   = 2'd2;

  localparam logic [1:0] LV_FREE    = 2'd0;
  localparam logic [1:0] LV_DEVICE  = 2'd1;
  localparam logic [1:0] LV_SHARED  = 2'd2;
  localparam logic [1:0] LV_STARTED = 2'd3;

  localparam logic [5:0] LIMIT_MAX     = 6'd63;
  localparam logic [3:0] INSTANCES_MAX = 4'd15;

  typedef struct packed {
    logic exec;
    logic promote;
    logic dispatch;
    logic finish;
  } tlct_cmd_t;

  typedef struct packed {
    logic promote_more;
  } tlct_stat_t;

endpackage

@@ rtl/tlct_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlct_ctrl
// Sequencer: execute the request, promote tags one per cycle, dispatch, finish.
// ----------------------------------------------------------------------------
module tlct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tlct_pkg::tlct_stat_t stat,
  output tlct_pkg::tlct_cmd_t  cmd,
  output logic                busy
);
  import tlct_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PROMOTE, S_DISPATCH, S_FINISH} state_t;
  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:     if (start) state <= S_EXEC;
        S_EXEC:     state <= S_PROMOTE;
        S_PROMOTE:  if (!stat.promote_more) state <= S_DISPATCH;
        S_DISPATCH: state <= S_FINISH;
        S_FINISH:   state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.exec     = (state == S_EXEC);
    cmd.promote  = (state == S_PROMOTE);
    cmd.dispatch = (state == S_DISPATCH);
    cmd.finish   = (state == S_FINISH);
  end

  assign busy = (state != S_IDLE);
endmodule

@@ rtl/tlct_dp.sv @@
// ----------------------------------------------------------------------------
// tlct_dp
// Tag lists, device and controller counters, and the result register.
// ----------------------------------------------------------------------------
module tlct_dp #(
  parameter int NUM_TAGS    = 32,
  parameter int NUM_DEVICES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  tlct_pkg::tlct_cmd_t  cmd,
  output tlct_pkg::tlct_stat_t stat,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_data,
  input  logic [2:0]          kind,
  input  logic [4:0]          tag,
  input  logic [2:0]          device,
  input  logic                accepted,
  input  logic [15:0]         value,
  output logic                strobe,
  output logic                issue_valid,
  output logic [4:0]          issue_tag,
  output logic [2:0]          issue_device,
  output logic [1:0]          status,
  output logic [5:0]          controller_active
);
  import tlct_pkg::*;

  localparam int TW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
  localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int CW = $clog2(NUM_TAGS + 1);

  logic [1:0]    tag_level [NUM_TAGS];
  logic [DW-1:0] tag_owner [NUM_TAGS];
  logic [TW-1:0] tag_next  [NUM_TAGS];
  logic [TW-1:0] tag_prev  [NUM_TAGS];
  logic [TW-1:0] device_head [NUM_DEVICES];
  logic [TW-1:0] device_tail [NUM_DEVICES];
  logic [CW-1:0] device_count [NUM_DEVICES];
  logic [5:0]    device_active [NUM_DEVICES];
  logic [5:0]    device_limit [NUM_DEVICES];
  logic [3:0]    device_instances [NUM_DEVICES];
  logic [TW-1:0] shared_head, shared_tail;
  logic [CW-1:0] shared_count;
  logic [5:0]    started_count, max_active;
  logic          hold_flag, awaiting_reply;
  logic [15:0]   freeze_left;
  logic [TW-1:0] pending_tag;

  logic [2:0]    r_kind;
  logic [4:0]    r_tag;
  logic [2:0]    r_device;
  logic          r_acc;
  logic [15:0]   r_value;
  logic [1:0]    st;
  logic          run;
  logic          pen;
  logic [DW-1:0] pdev;

  logic          t_ok, d_ok;
  logic [TW-1:0] ti;
  logic [DW-1:0] di, oi;
  logic [5:0]    lim;
  logic [1:0]    lv;
  logic [TW-1:0] ph;
  logic          can_promote;

  always_comb begin
    t_ok = ({27'd0, r_tag} < 32'(NUM_TAGS));
    d_ok = ({29'd0, r_device} < 32'(NUM_DEVICES));
    ti   = TW'(r_tag);
    di   = DW'(r_device);
    oi   = tag_owner[ti];
    lv   = tag_level[ti];
    lim  = (r_value > 16'(LIMIT_MAX)) ? LIMIT_MAX : r_value[5:0];
    ph   = device_head[pdev];
    can_promote = pen && (device_active[pdev] < device_limit[pdev]) &&
                  !(device_instances[pdev] > 4'd1 && device_active[pdev] != 6'd0) &&
                  (device_count[pdev] != '0);
  end

  assign stat.promote_more = can_promote;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_active <= 6'd1;
    end else if (cfg_we) begin
      max_active <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAGS; i++) tag_level[i] <= LV_FREE;
      for (int i = 0; i < NUM_DEVICES; i++) begin
        device_count[i]     <= '0;
        device_active[i]    <= '0;
        device_limit[i]     <= 6'd1;
        device_instances[i] <= '0;
      end
      shared_head    <= '0;
      shared_tail    <= '0;
      shared_count   <= '0;
      started_count  <= '0;
      hold_flag      <= 1'b0;
      freeze_left    <= '0;
      awaiting_reply <= 1'b0;
      pending_tag    <= '0;
      strobe         <= 1'b0;
      issue_valid    <= 1'b0;
      issue_tag      <= '0;
      issue_device   <= '0;
      status         <= ST_OK;
      controller_active <= '0;
      run            <= 1'b0;
      pen            <= 1'b0;
      st             <= ST_OK;
      pdev           <= '0;
    end else begin
      strobe <= 1'b0;
      if (start && !busy) begin
        r_kind   <= kind;
        r_tag    <= tag;
        r_device <= device;
        r_acc    <= accepted;
        r_value  <= value;
      end
      if (cmd.exec) begin
        st  <= ST_OK;
        run <= 1'b1;
        pen <= 1'b0;
        pdev <= di;
        if (awaiting_reply && r_kind != KIND_REPLY && r_kind != KIND_TICK) begin
          st  <= ST_IGNORED;
          run <= 1'b0;
          pdev <= '0;
        end else begin
          case (r_kind)
            KIND_SUBMIT: begin
              if (!t_ok || !d_ok || lv != LV_FREE || device_instances[di] == 4'd0) begin
                st <= ST_WRONG;
              end else begin
                pen <= 1'b1;
                tag_owner[ti] <= di;
                tag_level[ti] <= LV_DEVICE;
                if (device_count[di] == '0) begin
                  device_head[di] <= ti;
                end else begin
                  tag_next[device_tail[di]] <= ti;
                  tag_prev[ti] <= device_tail[di];
                end
                device_tail[di]  <= ti;
                device_count[di] <= device_count[di] + 1'b1;
              end
            end
            KIND_DELETE: begin
              if (!t_ok || lv == LV_FREE) begin
                st <= ST_WRONG;
                pdev <= '0;
              end else begin
                pen <= 1'b1;
                pdev <= oi;
                if (lv == LV_DEVICE && device_count[oi] != '0) begin
                  if (device_count[oi] != CW'(1)) begin
                    if (device_head[oi] == ti) device_head[oi] <= tag_next[ti];
                    else if (device_tail[oi] == ti) device_tail[oi] <= tag_prev[ti];
                    else begin
                      tag_next[tag_prev[ti]] <= tag_next[ti];
                      tag_prev[tag_next[ti]] <= tag_prev[ti];
                    end
                  end
                  device_count[oi] <= device_count[oi] - 1'b1;
                end
                if (lv == LV_SHARED && shared_count != '0) begin
                  if (shared_count != CW'(1)) begin
                    if (shared_head == ti) shared_head <= tag_next[ti];
                    else if (shared_tail == ti) shared_tail <= tag_prev[ti];
                    else begin
                      tag_next[tag_prev[ti]] <= tag_next[ti];
                      tag_prev[tag_next[ti]] <= tag_prev[ti];
                    end
                  end
                  shared_count <= shared_count - 1'b1;
                end
                if (lv[1] && device_active[oi] != '0)
                  device_active[oi] <= device_active[oi] - 1'b1;
                if (lv == LV_STARTED && started_count != '0)
                  started_count <= started_count - 1'b1;
                tag_level[ti] <= LV_FREE;
              end
            end
            KIND_REPLY: begin
              if (!awaiting_reply) begin
                st <= ST_WRONG;
              end else begin
                awaiting_reply <= 1'b0;
                if (!r_acc) begin
                  if (started_count != '0) started_count <= started_count - 1'b1;
                  tag_level[pending_tag] <= LV_SHARED;
                  if (shared_count == '0) begin
                    shared_tail <= pending_tag;
                  end else begin
                    tag_prev[shared_head] <= pending_tag;
                    tag_next[pending_tag] <= shared_head;
                  end
                  shared_head  <= pending_tag;
                  shared_count <= shared_count + 1'b1;
                  run <= 1'b0;
                end
              end
              pdev <= '0;
            end
            KIND_TICK: begin
              if (freeze_left != '0) freeze_left <= freeze_left - 1'b1;
            end
            KIND_FREEZE: freeze_left <= r_value;
            KIND_HOLD:   hold_flag <= r_value[0];
            KIND_ATTACH: begin
              if (!d_ok || device_instances[di] >= INSTANCES_MAX) begin
                st <= ST_WRONG;
              end else begin
                if (device_instances[di] == 4'd0) begin
                  device_limit[di]  <= lim;
                  device_active[di] <= '0;
                  device_count[di]  <= '0;
                end
                device_instances[di] <= device_instances[di] + 1'b1;
              end
            end
            default: begin
              if (!d_ok || device_instances[di] == 4'd0 ||
                  (device_instances[di] == 4'd1 &&
                   (device_count[di] != '0 || device_active[di] != '0))) begin
                st <= ST_WRONG;
              end else begin
                device_instances[di] <= device_instances[di] - 1'b1;
                if (device_instances[di] == 4'd2) device_limit[di] <= lim;
              end
            end
          endcase
        end
      end
      if (cmd.promote && can_promote) begin
        if (device_count[pdev] != CW'(1)) device_head[pdev] <= tag_next[ph];
        device_count[pdev] <= device_count[pdev] - 1'b1;
        if (shared_count == '0) begin
          shared_head <= ph;
        end else begin
          tag_next[shared_tail] <= ph;
          tag_prev[ph] <= shared_tail;
        end
        shared_tail  <= ph;
        shared_count <= shared_count + 1'b1;
        device_active[pdev] <= device_active[pdev] + 1'b1;
        tag_level[ph] <= LV_SHARED;
      end
      if (cmd.dispatch) begin
        issue_valid  <= 1'b0;
        issue_tag    <= '0;
        issue_device <= '0;
        if (run && !awaiting_reply && shared_count != '0 &&
            started_count < max_active && !hold_flag && freeze_left == '0) begin
          if (shared_count != CW'(1)) shared_head <= tag_next[shared_head];
          shared_count   <= shared_count - 1'b1;
          started_count  <= started_count + 1'b1;
          tag_level[shared_head] <= LV_STARTED;
          awaiting_reply <= 1'b1;
          pending_tag    <= shared_head;
          issue_valid    <= 1'b1;
          issue_tag      <= 5'(shared_head);
          issue_device   <= 3'(tag_owner[shared_head]);
        end
      end
      if (cmd.finish) begin
        strobe            <= 1'b1;
        status            <= st;
        controller_active <= started_count;
      end
    end
  end
endmodule

@@ rtl/two_level_command_throttle_top.sv @@
// Each request steps through execute, promote (one tag moved from the device queue
// per step, at most NUM_TAGS), dispatch and finish; busy drops as the result strobe
// rises, so the next request is taken at the edge that ends the strobe cycle.
// One request at a time; throughput is set by the promotion walk over the
// device queue. The receiver cannot stall; the result shows for one cycle.
// Synchronous reset clears all queues, counters and the limit to one.
module two_level_command_throttle_top #(
  parameter int NUM_TAGS    = 32,
  parameter int NUM_DEVICES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic [2:0]  kind,
  input  logic [4:0]  tag,
  input  logic [2:0]  device,
  input  logic        accepted,
  input  logic [15:0] value,
  output logic        strobe,
  output logic        issue_valid,
  output logic [4:0]  issue_tag,
  output logic [2:0]  issue_device,
  output logic [1:0]  status,
  output logic [5:0]  controller_active
);
  import tlct_pkg::*;

  tlct_cmd_t  cmd;
  tlct_stat_t stat;

  tlct_ctrl u_ctrl (.clk, .rst, .start, .stat, .cmd, .busy);

  tlct_dp #(.NUM_TAGS(NUM_TAGS), .NUM_DEVICES(NUM_DEVICES)) u_dp (
    .clk, .rst, .start, .busy, .cmd, .stat, .cfg_we, .cfg_data,
    .kind, .tag, .device, .accepted, .value,
    .strobe, .issue_valid, .issue_tag, .issue_device, .status, .controller_active
  );
endmodule

@@ bench/two_level_command_throttle_top_tb.sv @@
// ----------------------------------------------------------------------------
// two_level_command_throttle_top_tb
// Drives submit, delete, start reply, tick, freeze, hold, attach and detach
// requests into the throttle and checks every result strobe, field by field, against
// typed expected values for the first directed rows and otherwise a behavioral predictor
// of the device queues, the shared queue and the started commands, over several controller limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_level_command_throttle_top_tb;
  import tlct_pkg::*;

  typedef struct {
    logic       iv;
    logic [4:0] itag;
    logic [2:0] idev;
    logic [1:0] st;
    logic [5:0] act;
  } issue_t;

  typedef struct {
    logic [2:0]  k;
    logic [4:0]  t;
    logic [2:0]  d;
    logic        a;
    logic [15:0] v;
    bit          typed;
    issue_t      want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic [2:0]  kind = '0;
  logic [4:0]  tag = '0;
  logic [2:0]  device = '0;
  logic        accepted = 1'b0;
  logic [15:0] value = '0;
  logic        strobe;
  logic        issue_valid;
  logic [4:0]  issue_tag;
  logic [2:0]  issue_device;
  logic [1:0]  status;
  logic [5:0]  controller_active;

  two_level_command_throttle_top dut (
    .clk, .rst, .start, .busy, .cfg_we, .cfg_data,
    .kind, .tag, .device, .accepted, .value,
    .strobe, .issue_valid, .issue_tag, .issue_device, .status, .controller_active
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("two_level_command_throttle_top: mismatch");
    $finish;
  end

  // throttle state mirror; entry 8 of the queues is the shared queue
  localparam int SHARED_Q = 8;
  logic [1:0] lvl [32];
  int         owner [32];
  int         nxt [32];
  int         prv [32];
  int         qhead [9];
  int         qtail [9];
  int         qcount [9];
  int         dev_active [8];
  int         dev_limit [8];
  int         dev_inst [8];
  int         started_cnt, freeze_left, pend_tag, max_active;
  bit         hold_on, awaiting;

  issue_t issue_q[$];
  int     errors = 0;
  row_t   dir_rows[$];
  bit     quiet = 1'b0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void push_tail(input int q, input int t);
    if (qcount[q] == 0) qhead[q] = t;
    else begin
      nxt[qtail[q]] = t;
      prv[t] = qtail[q];
    end
    qtail[q] = t;
    qcount[q]++;
  endfunction

  function automatic void push_head(input int q, input int t);
    if (qcount[q] == 0) qtail[q] = t;
    else begin
      prv[qhead[q]] = t;
      nxt[t] = qhead[q];
    end
    qhead[q] = t;
    qcount[q]++;
  endfunction

  function automatic void unlink(input int q, input int t);
    if (qcount[q] == 0) return;
    if (qcount[q] == 1) begin
      qcount[q] = 0;
      return;
    end
    if (qhead[q] == t) qhead[q] = nxt[t];
    else if (qtail[q] == t) qtail[q] = prv[t];
    else begin
      nxt[prv[t]] = nxt[t];
      prv[nxt[t]] = prv[t];
    end
    qcount[q]--;
  endfunction

  function automatic void promote_device(input int d);
    int t;
    while (dev_active[d] < dev_limit[d] && !(dev_inst[d] > 1 && dev_active[d] > 0) &&
           qcount[d] != 0) begin
      t = qhead[d];
      unlink(d, t);
      push_tail(SHARED_Q, t);
      dev_active[d]++;
      lvl[t] = LV_SHARED;
    end
  endfunction

  function automatic void reset_mirror();
    for (int i = 0; i < 32; i++) begin
      lvl[i] = LV_FREE; owner[i] = 0; nxt[i] = 0; prv[i] = 0;
    end
    for (int i = 0; i < 9; i++) begin
      qhead[i] = 0; qtail[i] = 0; qcount[i] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      dev_active[i] = 0; dev_limit[i] = 1; dev_inst[i] = 0;
    end
    started_cnt = 0; freeze_left = 0; pend_tag = 0; max_active = 1;
    hold_on = 0; awaiting = 0;
  endfunction

  function automatic issue_t throttle_step(input logic [2:0] k, input int t, input int d,
                                           input logic a, input int v);
    issue_t r;
    int     lim, o, lv;
    bit     run;
    lim = (v > 63) ? 63 : v;
    run = 1'b1;
    r.iv = 0; r.itag = '0; r.idev = '0; r.st = ST_OK;
    if (awaiting && k != KIND_REPLY && k != KIND_TICK) begin
      r.st = ST_IGNORED;
      run = 1'b0;
    end else begin
      case (k)
        KIND_SUBMIT: begin
          if (lvl[t] != LV_FREE || dev_inst[d] == 0) r.st = ST_WRONG;
          else begin
            owner[t] = d;
            lvl[t] = LV_DEVICE;
            push_tail(d, t);
            promote_device(d);
          end
        end
        KIND_DELETE: begin
          if (lvl[t] == LV_FREE) r.st = ST_WRONG;
          else begin
            o = owner[t];
            lv = lvl[t];
            if (lv == LV_DEVICE) unlink(o, t);
            if (lv == LV_SHARED) unlink(SHARED_Q, t);
            if (lv >= LV_SHARED && dev_active[o] > 0) dev_active[o]--;
            if (lv == LV_STARTED && started_cnt > 0) started_cnt--;
            lvl[t] = LV_FREE;
            promote_device(o);
          end
        end
        KIND_REPLY: begin
          if (!awaiting) r.st = ST_WRONG;
          else begin
            awaiting = 0;
            if (!a) begin
              if (started_cnt > 0) started_cnt--;
              lvl[pend_tag] = LV_SHARED;
              push_head(SHARED_Q, pend_tag);
              run = 1'b0;
            end
          end
        end
        KIND_TICK: if (freeze_left > 0) freeze_left--;
        KIND_FREEZE: freeze_left = v;
        KIND_HOLD: hold_on = v[0];
        KIND_ATTACH: begin
          if (dev_inst[d] >= INSTANCES_MAX) r.st = ST_WRONG;
          else begin
            if (dev_inst[d] == 0) begin
              dev_limit[d] = lim;
              dev_active[d] = 0;
              qcount[d] = 0;
            end
            dev_inst[d]++;
          end
        end
        default: begin
          if (dev_inst[d] == 0 ||
              (dev_inst[d] == 1 && (qcount[d] > 0 || dev_active[d] > 0))) r.st = ST_WRONG;
          else begin
            dev_inst[d]--;
            if (dev_inst[d] == 1) dev_limit[d] = lim;
          end
        end
      endcase
    end
    if (run && !awaiting && qcount[SHARED_Q] != 0 && started_cnt < max_active &&
        !hold_on && freeze_left == 0) begin
      o = qhead[SHARED_Q];
      unlink(SHARED_Q, o);
      started_cnt++;
      lvl[o] = LV_STARTED;
      awaiting = 1;
      pend_tag = o;
      r.iv = 1; r.itag = o[4:0]; r.idev = owner[o][2:0];
    end
    r.act = started_cnt[5:0];
    return r;
  endfunction

  always @(posedge clk) begin
    issue_t e;
    if (!rst && strobe) begin
      if (issue_q.size() == 0) report("result with no request outstanding");
      else begin
        e = issue_q.pop_front();
        if (issue_valid !== e.iv) report($sformatf("issue_valid %b exp %b", issue_valid, e.iv));
        if (issue_tag !== e.itag) report($sformatf("issue_tag %0d exp %0d", issue_tag, e.itag));
        if (issue_device !== e.idev)
          report($sformatf("issue_device %0d exp %0d", issue_device, e.idev));
        if (status !== e.st) report($sformatf("status %0d exp %0d", status, e.st));
        if (controller_active !== e.act)
          report($sformatf("controller_active %0d exp %0d", controller_active, e.act));
      end
    end
  end

  task automatic send(input logic [2:0] k, input int t, input int d, input logic a,
                      input int v, input bit typed, input issue_t want);
    issue_t p;
    start <= 1'b1;
    kind <= k; tag <= t[4:0]; device <= d[2:0]; accepted <= a; value <= v[15:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    p = throttle_step(k, t, d, a, v);
    issue_q.push_back(typed ? want : p);
  endtask

  task automatic gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_limit(input logic [5:0] lim);
    start <= 1'b0;
    @(posedge clk);
    while (issue_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_active = lim;
  endtask

  function automatic void row(input logic [2:0] k, input int t, input int d, input logic a,
                              input int v, input bit typed = 0, input logic iv = 0,
                              input int it = 0, input int id = 0,
                              input logic [1:0] st = ST_OK, input int act = 0);
    row_t x;
    x.k = k; x.t = t; x.d = d; x.a = a; x.v = v; x.typed = typed;
    x.want.iv = iv; x.want.itag = it; x.want.idev = id; x.want.st = st; x.want.act = act;
    dir_rows.push_back(x);
  endfunction

  task automatic random_request();
    logic [2:0] k;
    int t, d, v, r, s;
    logic a;
    k = KIND_TICK; t = $urandom_range(0, 31); d = $urandom_range(0, 7);
    a = ($urandom_range(0, 3) != 0); v = $urandom_range(0, 65535);
    r = $urandom_range(0, 99);
    if (awaiting && r < 75) k = KIND_REPLY;
    else if (awaiting && r < 85) k = KIND_TICK;
    else begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        k = KIND_SUBMIT;
        if ($urandom_range(0, 4) != 0) begin
          s = t;
          for (int i = 0; i < 32; i++) if (lvl[(s + i) % 32] == LV_FREE) t = (s + i) % 32;
          s = d;
          for (int i = 0; i < 8; i++) if (dev_inst[(s + i) % 8] != 0) d = (s + i) % 8;
        end
      end else if (r < 50) begin
        k = KIND_DELETE;
        if ($urandom_range(0, 9) < 7) begin
          s = t;
          for (int i = 0; i < 32; i++) if (lvl[(s + i) % 32] != LV_FREE) t = (s + i) % 32;
        end
      end else if (r < 58) k = KIND_REPLY;
      else if (r < 68) k = KIND_TICK;
      else if (r < 75) begin
        k = KIND_FREEZE;
        if ($urandom_range(0, 9) != 0) v = $urandom_range(0, 3);
      end else if (r < 83) begin
        k = KIND_HOLD;
        v[0] = ($urandom_range(0, 9) < 3);
      end else if (r < 93) begin
        k = KIND_ATTACH;
        if ($urandom_range(0, 9) < 7) v = $urandom_range(0, 4);
      end else begin
        k = KIND_DETACH;
        if ($urandom_range(0, 9) < 7) v = $urandom_range(0, 4);
      end
    end
    send(k, t, d, a, v, 0, '{default: '0});
  endtask

  initial begin
    logic [5:0] limits [5];
    reset_mirror();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    row(KIND_TICK,   0, 0, 0, 0,     1, 0, 0, 0, ST_OK,    0);
    row(KIND_REPLY,  0, 0, 1, 0,     1, 0, 0, 0, ST_WRONG, 0);
    row(KIND_SUBMIT, 3, 2, 0, 0,     1, 0, 0, 0, ST_WRONG, 0);
    row(KIND_DELETE, 5, 0, 0, 0,     1, 0, 0, 0, ST_WRONG, 0);
    row(KIND_DETACH, 0, 4, 0, 0,     1, 0, 0, 0, ST_WRONG, 0);
    row(KIND_ATTACH, 0, 0, 0, 65535, 1, 0, 0, 0, ST_OK,    0);
    row(KIND_ATTACH, 0, 7, 0, 0,     1, 0, 0, 0, ST_OK,    0);
    row(KIND_SUBMIT, 31, 7, 0, 0,    1, 0, 0, 0, ST_OK,    0);
    row(KIND_SUBMIT, 0, 0, 0, 0,     1, 1, 0, 0, ST_OK,    1);
    row(KIND_HOLD,   0, 0, 0, 1,     1, 0, 0, 0, ST_IGNORED, 1);
    row(KIND_REPLY,  0, 0, 1, 0,     1, 0, 0, 0, ST_OK,    1);
    row(KIND_SUBMIT, 1, 0, 0, 0);
    row(KIND_HOLD,   0, 0, 0, 65535);
    row(KIND_SUBMIT, 2, 0, 0, 0);
    row(KIND_DELETE, 0, 0, 0, 0);
    row(KIND_HOLD,   0, 0, 0, 65534);
    row(KIND_REPLY,  0, 0, 0, 0);
    row(KIND_FREEZE, 0, 0, 0, 2);
    row(KIND_TICK,   0, 0, 0, 0);
    row(KIND_TICK,   0, 0, 0, 0);
    row(KIND_REPLY,  0, 0, 1, 0);
    row(KIND_DELETE, 31, 0, 0, 0);
    for (int i = 0; i < 15; i++) row(KIND_ATTACH, 0, 5, 0, 3);
    row(KIND_DETACH, 0, 7, 0, 0);
    row(KIND_DETACH, 0, 5, 0, 40000);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].k, dir_rows[i].t, dir_rows[i].d, dir_rows[i].a, dir_rows[i].v,
           dir_rows[i].typed, dir_rows[i].want);
      gap();
    end

    limits = '{6'd32, 6'd0, 6'd31, 6'($urandom_range(1, 32)), 6'd1};
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 310; n++) begin
        random_request();
        gap();
      end
    end

    start <= 1'b0;
    while (issue_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("two_level_command_throttle_top: match");
    else $display("two_level_command_throttle_top: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tlct_pkg.sv
rtl/tlct_ctrl.sv
rtl/tlct_dp.sv
rtl/two_level_command_throttle_top.sv
bench/two_level_command_throttle_top_tb.sv
